/* src/frot_pkg.sv */
// ----------------------------------------------------------------------------
// frot_pkg
// Types and codes shared by the rotating frame store.
// ----------------------------------------------------------------------------
package frot_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int DIM_REG_W   = 9;
  localparam int ANGLE_W     = 2;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 9'd256;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROTATION_ANGLE = 2'd2;

  // rotation codes; the spare code behaves as a quarter turn
  localparam logic [ANGLE_W-1:0] ANGLE_90  = 2'd0;
  localparam logic [ANGLE_W-1:0] ANGLE_180 = 2'd1;
  localparam logic [ANGLE_W-1:0] ANGLE_270 = 2'd2;

  // request opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDR,
    S_READ,
    S_OUT
  } state_t;

endpackage

/* src/frame_rotator_90_180_270.sv */
// ----------------------------------------------------------------------------
// frame_rotator_90_180_270
// Frame store for RGB pixels with read-out rotated by 90, 180 or 270 degrees.
// ----------------------------------------------------------------------------
//  channel   signals                          direction  transfer
//  request   start, busy, item                in         start && !busy
//  result    strobe, result                   out        one cycle, strobe high
//  config    cfg_we, cfg_index, cfg_data      in         cfg_we
//
//  A write request is stored in the cycle it is taken. A fetch request
//  goes through address set-up, address multiply-add, RAM read and result,
//  in that order; the single read port and the row multiply set these steps.
//  busy is high in the address and read states; a new request can be taken
//  in the result cycle. Results cannot be stalled. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module frame_rotator_90_180_270 import frot_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  in_item_t               item,
  output logic                   strobe,
  output result_t                result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = $clog2(DEPTH);
  localparam int MAXDIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_LIM = (MAXDIM > 511) ? 511 : MAXDIM;
  localparam int DW      = $clog2(DIM_LIM + 1);   // effective dimension
  localparam int CW      = $clog2(DIM_LIM);       // coordinate
  localparam int PW      = CW + DW;

  // configuration
  logic [DIM_REG_W-1:0] image_width;
  logic [DIM_REG_W-1:0] image_height;
  logic [ANGLE_W-1:0]   rotation_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= DIM_RESET;
      image_height   <= DIM_RESET;
      rotation_angle <= ANGLE_90;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:    image_width    <= cfg_data[DIM_REG_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data[DIM_REG_W-1:0];
        REG_ROTATION_ANGLE: rotation_angle <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective dimensions and derived sizes
  logic [DW-1:0]   w;
  logic [DW-1:0]   h;
  logic [2*DW-1:0] total;
  logic [DW-1:0]   ow;
  logic [DW-1:0]   oh;
  logic            half_turn;
  logic            turn_270;

  always_comb begin
    if (image_width == '0) begin
      w = DW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w = DW'(MAX_WIDTH);
    end else begin
      w = DW'(image_width);
    end
    if (image_height == '0) begin
      h = DW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h = DW'(MAX_HEIGHT);
    end else begin
      h = DW'(image_height);
    end
    total     = w * h;
    half_turn = (rotation_angle == ANGLE_180);
    turn_270  = (rotation_angle == ANGLE_270);
    ow        = half_turn ? w : h;
    oh        = half_turn ? h : w;
  end

  // control
  state_t state;
  state_t state_next;
  logic   accept;
  logic   take_write;
  logic   take_fetch;

  assign busy       = (state == S_ADDR) || (state == S_READ);
  assign accept     = start && !busy;
  assign take_write = accept && (item.op == OP_WRITE);
  assign take_fetch = accept && (item.op == OP_FETCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  state_next = take_fetch ? S_ADDR : S_IDLE;
      S_ADDR:  state_next = S_READ;
      S_READ:  state_next = S_OUT;
      S_OUT:   state_next = take_fetch ? S_ADDR : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // write side: pixel goes straight into the store
  logic [AW-1:0] write_position;
  logic [AW-1:0] wp_eff;
  logic [AW:0]   wp_inc;

  always_comb begin
    wp_eff = (32'(write_position) >= 32'(total)) ? '0 : write_position;
    wp_inc = {1'b0, wp_eff} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
    end else if (take_write) begin
      write_position <= (32'(wp_inc) >= 32'(total)) ? '0 : wp_inc[AW-1:0];
    end
  end

  // fetch side: output raster counters and source coordinates
  logic [CW-1:0] out_column;
  logic [CW-1:0] out_row;
  logic [DW-1:0] col_eff;
  logic [DW-1:0] row_eff;
  logic [DW-1:0] col_inc;
  logic [DW-1:0] row_inc;
  logic [DW-1:0] sx_w;
  logic [DW-1:0] sy_w;
  logic          last_w;

  always_comb begin
    col_eff = DW'(out_column);
    row_eff = DW'(out_row);
    if (col_eff >= ow || row_eff >= oh) begin
      col_eff = '0;
      row_eff = '0;
    end
    if (half_turn) begin
      sx_w = w - 1'b1 - col_eff;
      sy_w = h - 1'b1 - row_eff;
    end else if (turn_270) begin
      sx_w = w - 1'b1 - row_eff;
      sy_w = col_eff;
    end else begin
      sx_w = row_eff;
      sy_w = h - 1'b1 - col_eff;
    end
    last_w  = (col_eff == ow - 1'b1) && (row_eff == oh - 1'b1);
    col_inc = col_eff + 1'b1;
    row_inc = row_eff + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_column <= '0;
      out_row    <= '0;
    end else if (take_fetch) begin
      if (col_inc >= ow) begin
        out_column <= '0;
        out_row    <= (row_inc >= oh) ? '0 : CW'(row_inc);
      end else begin
        out_column <= CW'(col_inc);
        out_row    <= CW'(row_eff);
      end
    end
  end

  // address pipeline
  logic [CW-1:0]  sx;
  logic [CW-1:0]  sy;
  logic           frame_end;
  logic [AW-1:0]  addr;
  logic [PW-1:0]  row_base;

  assign row_base = sy * w;

  always_ff @(posedge clk) begin
    if (take_fetch) begin
      sx        <= CW'(sx_w);
      sy        <= CW'(sy_w);
      frame_end <= last_w;
    end
    if (state == S_ADDR) begin
      addr <= AW'(row_base) + AW'(sx);
    end
  end

  logic [23:0] rd_pixel;

  frot_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (take_write),
    .waddr (wp_eff),
    .wdata ({item.red_in, item.green_in, item.blue_in}),
    .raddr (addr),
    .rdata (rd_pixel)
  );

  assign strobe            = (state == S_OUT);
  assign result.red_out    = rd_pixel[23:16];
  assign result.green_out  = rd_pixel[15:8];
  assign result.blue_out   = rd_pixel[7:0];
  assign result.frame_last = frame_end;

  // checks
  a_strobe_follows_fetch: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(take_fetch, 3))
    else $error("result without a fetch request three cycles before");

  a_last_wraps_counters: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.frame_last) |-> (out_column == '0 && out_row == '0))
    else $error("output counters not back at origin after last pixel");

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(write_position))
    else $error("write position moved while a fetch was in flight");

endmodule

/* src/frot_ram.sv */
// ----------------------------------------------------------------------------
// frot_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module frot_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* tb/frot_pixel_checker.sv */
// ----------------------------------------------------------------------------
// frot_pixel_checker
// Watches the request, result and register channels of the rotating frame
// store. It keeps its own frame memory, counters and settings, works out the
// rotated pixel that each fetch request must return, and compares every
// result strobe against the oldest outstanding pixel.
// ----------------------------------------------------------------------------
module frot_pixel_checker import frot_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  in_item_t               item,
  input  logic                   strobe,
  input  result_t                result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     errors,
  output int                     pending,
  output int                     pixels_checked,
  output int                     frame_ends
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W       = 256;
  localparam int MAX_H       = 256;
  localparam int STORE_DEPTH = MAX_W * MAX_H;

  logic [23:0]          frame_mem [STORE_DEPTH];
  logic [15:0]          wr_pos;
  logic [7:0]           out_x;
  logic [7:0]           out_y;
  logic [DIM_REG_W-1:0] width_reg;
  logic [DIM_REG_W-1:0] height_reg;
  logic [ANGLE_W-1:0]   angle_reg;
  result_t              expected_pixels [$];

  // zero acts as one, anything above the maximum as the maximum
  function automatic int eff_dim(input logic [DIM_REG_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic void store_pixel(input in_item_t it);
    int total;
    int pos;
    total = eff_dim(width_reg, MAX_W) * eff_dim(height_reg, MAX_H);
    pos   = int'(wr_pos);
    if (pos >= total) pos = 0;
    frame_mem[pos] = {it.red_in, it.green_in, it.blue_in};
    pos++;
    if (pos >= total) pos = 0;
    wr_pos = pos[15:0];
  endfunction

  function automatic result_t next_rotated_pixel();
    int          w;
    int          h;
    int          ow;
    int          oh;
    int          x;
    int          y;
    int          sx;
    int          sy;
    logic [23:0] pix;
    result_t     r;
    w = eff_dim(width_reg, MAX_W);
    h = eff_dim(height_reg, MAX_H);
    if (angle_reg == ANGLE_180) begin
      ow = w;
      oh = h;
    end else begin
      ow = h;
      oh = w;
    end
    x = int'(out_x);
    y = int'(out_y);
    // a register change may leave the read-out position off the frame
    if (x >= ow || y >= oh) begin
      x = 0;
      y = 0;
    end
    case (angle_reg)
      ANGLE_180: begin
        sx = w - 1 - x;
        sy = h - 1 - y;
      end
      ANGLE_270: begin
        sx = w - 1 - y;
        sy = x;
      end
      default: begin
        sx = y;
        sy = h - 1 - x;
      end
    endcase
    pix          = frame_mem[sy * w + sx];
    r.red_out    = pix[23:16];
    r.green_out  = pix[15:8];
    r.blue_out   = pix[7:0];
    r.frame_last = (x == ow - 1) && (y == oh - 1);
    x++;
    if (x >= ow) begin
      x = 0;
      y++;
      if (y >= oh) y = 0;
    end
    out_x = x[7:0];
    out_y = y[7:0];
    return r;
  endfunction

  task automatic report(input string what);
    errors++;
    if (errors <= 20) $display("%0t ns  mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      wr_pos         = '0;
      out_x          = '0;
      out_y          = '0;
      width_reg      = DIM_RESET;
      height_reg     = DIM_RESET;
      angle_reg      = ANGLE_90;
      errors         = 0;
      pixels_checked = 0;
      frame_ends     = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:    width_reg  = cfg_data[DIM_REG_W-1:0];
          REG_IMAGE_HEIGHT:   height_reg = cfg_data[DIM_REG_W-1:0];
          REG_ROTATION_ANGLE: angle_reg  = cfg_data[ANGLE_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (item.op == OP_FETCH) expected_pixels.push_back(next_rotated_pixel());
        else store_pixel(item);
      end
      if (strobe) begin
        if (expected_pixels.size() == 0) begin
          report("pixel result with no fetch request outstanding");
        end else begin
          want = expected_pixels.pop_front();
          if (result.red_out !== want.red_out)
            report($sformatf("red got %0h want %0h", result.red_out, want.red_out));
          if (result.green_out !== want.green_out)
            report($sformatf("green got %0h want %0h", result.green_out, want.green_out));
          if (result.blue_out !== want.blue_out)
            report($sformatf("blue got %0h want %0h", result.blue_out, want.blue_out));
          if (result.frame_last !== want.frame_last)
            report($sformatf("frame_last got %0b want %0b", result.frame_last,
                             want.frame_last));
          pixels_checked++;
          if (want.frame_last) frame_ends++;
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

/* tb/tb_frame_rotator_90_180_270.sv */
// ----------------------------------------------------------------------------
// tb_frame_rotator_90_180_270
// Drives the rotating frame store through a series of frame settings: each
// one fills the whole source frame, then fetches rotated pixels with stray
// writes mixed in. A short directed opening covers every angle, the spare
// angle code, dimension clamping, wrap-round and counter restarts; random
// settings follow. Checking is left to frot_pixel_checker.
// ----------------------------------------------------------------------------
module tb_frame_rotator_90_180_270 import frot_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W        = 256;
  localparam int MAX_H        = 256;
  localparam int MAX_GAP      = 12;
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_ITEMS = 1000;
  localparam int LIMIT_CYCLES = 400000;

  // spare codes: an unused register index and the fourth angle code
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE   = 2'd3;
  localparam logic [ANGLE_W-1:0]     ANGLE_SPARE = 2'd3;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   start     = 1'b0;
  logic                   busy;
  in_item_t               req       = '0;
  logic                   pix_strobe;
  result_t                pix;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int errors;
  int pending;
  int pixels_checked;
  int frame_ends;
  int cycles       = 0;
  int writes_sent  = 0;
  int fetches_sent = 0;
  int phases       = 0;
  int gap_max      = 0;

  always #5 clk = ~clk;

  frame_rotator_90_180_270 #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (req),
    .strobe    (pix_strobe),
    .result    (pix),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  frot_pixel_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .item           (req),
    .strobe         (pix_strobe),
    .result         (pix),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .errors         (errors),
    .pending        (pending),
    .pixels_checked (pixels_checked),
    .frame_ends     (frame_ends)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("** frame_rotator_90_180_270: FAILED **");
      $finish;
    end
  end

  function automatic int dim_of(input logic [DIM_REG_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // mostly random colour, now and then all zeros or all ones
  function automatic logic [23:0] pixel_value();
    case ($urandom_range(0, 7))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic send_request(input logic op, input logic [23:0] rgb);
    int gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= {op, rgb};
    do @(posedge clk); while (busy !== 1'b0);
    if (op == OP_FETCH) fetches_sent++;
    else writes_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // wait out every outstanding fetch, then the pipeline depth
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // new settings, a full source frame, then fetches with stray writes mixed in
  task automatic run_frame(input logic [DIM_REG_W-1:0] w_reg,
                           input logic [DIM_REG_W-1:0] h_reg,
                           input logic [ANGLE_W-1:0]   a_reg,
                           input int                   n_fetch,
                           input int                   n_extra);
    int total;
    int fetch_left;
    int extra_left;
    wait_idle();
    if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
    write_reg(REG_IMAGE_WIDTH, w_reg);
    write_reg(REG_IMAGE_HEIGHT, h_reg);
    write_reg(REG_ROTATION_ANGLE, CFG_DATA_W'(a_reg));
    cfg_we  <= 1'b0;
    gap_max  = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
    total    = dim_of(w_reg, MAX_W) * dim_of(h_reg, MAX_H);
    // every entry of the frame is written before anything is fetched
    repeat (total) send_request(OP_WRITE, pixel_value());
    fetch_left = n_fetch;
    extra_left = n_extra;
    while (fetch_left + extra_left > 0) begin
      if ($urandom_range(1, fetch_left + extra_left) <= extra_left) begin
        send_request(OP_WRITE, pixel_value());
        extra_left--;
      end else begin
        send_request(OP_FETCH, 24'($urandom()));
        fetch_left--;
      end
    end
    phases++;
  endtask

  initial begin : stimulus
    int                   base;
    int                   total;
    logic [DIM_REG_W-1:0] w_reg;
    logic [DIM_REG_W-1:0] h_reg;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // 2x2 quarter turn, read-out wraps past the frame end, stray writes
    run_frame(9'd2, 9'd2, ANGLE_90, 7, 3);
    // zero width, spare angle code; both counters land off the new frame
    run_frame(9'd0, 9'd1, ANGLE_SPARE, 2, 0);
    run_frame(9'd3, 9'd1, ANGLE_180, 3, 0);
    run_frame(9'd1, 9'd2, ANGLE_270, 2, 0);

    base = writes_sent + fetches_sent;
    while (writes_sent + fetches_sent - base < RANDOM_ITEMS) begin
      case (phases)
        5: run_frame(9'd256, 9'd1, ANGLE_180, 257, 2);
        7: run_frame(9'd0, 9'd511, ANGLE_270, 30, 5);
        default: begin
          w_reg = DIM_REG_W'($urandom_range(0, 8));
          h_reg = DIM_REG_W'($urandom_range(0, 8));
          total = dim_of(w_reg, MAX_W) * dim_of(h_reg, MAX_H);
          run_frame(w_reg, h_reg, ANGLE_W'($urandom_range(0, 3)),
                    ($urandom_range(0, 1) == 0) ? total + $urandom_range(0, 3)
                                                : $urandom_range(1, 2 * total),
                    $urandom_range(0, total / 2 + 1));
        end
      endcase
    end
    wait_idle();

    $display("Ran %0d frame settings: %0d pixel writes and %0d fetch requests.",
             phases, writes_sent, fetches_sent);
    $display("Compared %0d rotated pixels, %0d of them closing a frame.",
             pixels_checked, frame_ends);
    if (errors == 0) begin
      $display("** frame_rotator_90_180_270: PASSED **");
    end else begin
      $display("** frame_rotator_90_180_270: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
src/frot_pkg.sv
src/frot_ram.sv
src/frame_rotator_90_180_270.sv
tb/frot_pixel_checker.sv
tb/tb_frame_rotator_90_180_270.sv
